// ===== hdl/sorted_breakpoint_interpolation_table_unit_assert.svh =====
// assertion macros used by the port-level checker
`ifndef SORTED_BREAKPOINT_INTERPOLATION_TABLE_UNIT_ASSERT_SVH
`define SORTED_BREAKPOINT_INTERPOLATION_TABLE_UNIT_ASSERT_SVH
// check an implication on every clock edge outside reset
`define SBIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// check an implication in the following cycle, outside reset
`define SBIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/sbit_pkg.sv =====
// shared constants and types for the breakpoint table
package sbit_pkg;
  localparam int MaxEntriesDefault = 32;
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_DEL   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;

  // request from the sequencer to the divider
  typedef struct packed {
    logic        start;
    logic [32:0] num_mag;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
    logic        rem_nz;
  } div_rsp_t;
endpackage

// ===== hdl/sbit_ram.sv =====
// generic single port ram with registered read
module sbit_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/sbit_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
module sbit_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sbit_pkg::div_req_t req,
  output sbit_pkg::div_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], q_r[32]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd33;
      q_nxt    = req.num_mag;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      q_nxt = {q_r[31:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = q_r;
  assign rsp.rem_nz = (rem_r != '0);
endmodule

// ===== hdl/sbit_ctrl.sv =====
// sequencer: scan, shift and interpolate over the key and value memories
module sbit_ctrl #(
  parameter int MaxEntries = sbit_pkg::MaxEntriesDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [15:0]              in_distance,
  input  logic signed [15:0]       in_entry_power,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_power,
  output logic [5:0]               out_entry_count,
  output logic [1:0]               out_status,
  output logic                     mem_we,
  output logic [$clog2(MaxEntries)-1:0] mem_addr,
  output logic [15:0]              key_wdata,
  output logic [15:0]              val_wdata,
  input  logic [15:0]              key_rdata,
  input  logic [15:0]              val_rdata,
  output sbit_pkg::div_req_t       div_req,
  input  sbit_pkg::div_rsp_t       div_rsp
);
  localparam int AW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DECIDE= 4'd3;
  localparam logic [3:0] S_SHR   = 4'd4;
  localparam logic [3:0] S_SHRW  = 4'd5;
  localparam logic [3:0] S_SHL   = 4'd6;
  localparam logic [3:0] S_SHLW  = 4'd7;
  localparam logic [3:0] S_PREV  = 4'd8;
  localparam logic [3:0] S_PREVW = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic signed [15:0] pw_r, pw_nxt;
  logic [15:0] k2_r, k2_nxt;
  logic signed [15:0] p2_r, p2_nxt;
  logic [15:0] k1_r, k1_nxt;
  logic signed [15:0] p1_r, p1_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] hk_r, hk_nxt;
  logic signed [15:0] hv_r, hv_nxt;

  logic signed [16:0] dp;
  logic [16:0] dx;
  logic signed [33:0] qs;
  logic signed [34:0] base;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; idx_nxt = idx_r; func_nxt = func_r;
    dist_nxt = dist_r; pw_nxt = pw_r; k2_nxt = k2_r; p2_nxt = p2_r;
    k1_nxt = k1_r; p1_nxt = p1_r; prod_nxt = prod_r; res_nxt = res_r;
    stat_nxt = stat_r; neg_nxt = neg_r;
    hk_nxt = hk_r; hv_nxt = hv_r;
    mem_we = 1'b0; mem_addr = idx_r[AW-1:0];
    key_wdata = dist_r; val_wdata = pw_r;
    div_req = '0;
    dp = 17'(p2_r) - 17'(p1_r);
    dx = {1'b0, dist_r} - {1'b0, k1_r};
    qs = '0; base = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func; dist_nxt = in_distance; pw_nxt = in_entry_power;
          idx_nxt = '0; res_nxt = '0; stat_nxt = sbit_pkg::ST_OK;
          st_nxt = (in_func == sbit_pkg::FUNC_NOP) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        if (idx_r >= cnt_r) st_nxt = S_DECIDE;
        else st_nxt = S_CMP;
      end
      S_CMP: begin
        k2_nxt = key_rdata; p2_nxt = val_rdata;
        if (key_rdata >= dist_r) st_nxt = S_DECIDE;
        else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = S_RD;
        end
      end
      S_DECIDE: begin
        // idx is the first entry not below distance; k2/p2 hold it if idx < count
        if (idx_r < cnt_r && k2_r == dist_r) begin
          if (func_r == sbit_pkg::FUNC_ADD) begin
            mem_we = 1'b1; st_nxt = S_OUT;
          end else if (func_r == sbit_pkg::FUNC_DEL) begin
            idx_nxt = idx_r + 1'b1; st_nxt = S_SHL;
          end else begin
            res_nxt = p2_r; st_nxt = S_OUT;
          end
        end else if (func_r == sbit_pkg::FUNC_ADD) begin
          if (cnt_r >= CW'(MaxEntries)) begin
            stat_nxt = sbit_pkg::ST_FULL; st_nxt = S_OUT;
          end else begin
            // insert here, carrying displaced entries upward
            hk_nxt = dist_r; hv_nxt = pw_r; st_nxt = S_SHR;
          end
        end else if (func_r == sbit_pkg::FUNC_DEL) begin
          stat_nxt = sbit_pkg::ST_ABSENT; st_nxt = S_OUT;
        end else begin
          if (cnt_r == '0) begin
            res_nxt = '0; st_nxt = S_OUT;
          end else if (idx_r == '0) begin
            res_nxt = p2_r; st_nxt = S_OUT;
          end else begin
            idx_nxt = idx_r - 1'b1; st_nxt = S_PREV;
          end
        end
      end
      S_SHR: begin
        // read old entry at idx, then write held one
        if (idx_r == cnt_r) begin
          mem_we = 1'b1; key_wdata = hk_r; val_wdata = hv_r;
          cnt_nxt = cnt_r + 1'b1; st_nxt = S_OUT;
        end else st_nxt = S_SHRW;
      end
      S_SHRW: begin
        mem_we = 1'b1; key_wdata = hk_r; val_wdata = hv_r;
        hk_nxt = key_rdata; hv_nxt = val_rdata;
        idx_nxt = idx_r + 1'b1; st_nxt = S_SHR;
      end
      S_SHL: begin
        if (idx_r == cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; st_nxt = S_OUT;
        end else st_nxt = S_SHLW;
      end
      S_SHLW: begin
        mem_we = 1'b1; mem_addr = AW'(idx_r - 1'b1);
        key_wdata = key_rdata; val_wdata = val_rdata;
        idx_nxt = idx_r + 1'b1; st_nxt = S_SHL;
      end
      S_PREV: st_nxt = S_PREVW;
      S_PREVW: begin
        k1_nxt = key_rdata; p1_nxt = val_rdata;
        // above the last entry: last power
        if (idx_r + 1'b1 >= cnt_r) begin
          res_nxt = val_rdata; st_nxt = S_OUT;
        end else st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = 34'(dp) * 34'(signed'(dx));
        st_nxt = S_DIV;
      end
      S_DIV: begin
        neg_nxt = prod_r[33];
        div_req.start = 1'b1;
        div_req.num_mag = prod_r[33] ? 33'(-prod_r) : prod_r[32:0];
        div_req.den = k2_r - k1_r;
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (div_rsp.done) begin
          // floor quotient, then truncate toward zero
          if (neg_r) qs = -34'(div_rsp.quot) - (div_rsp.rem_nz ? 34'sd1 : 34'sd0);
          else qs = 34'(div_rsp.quot);
          base = 35'(p1_r) + 35'(qs);
          if (div_rsp.rem_nz && base < 0) base = base + 35'sd1;
          res_nxt = base[15:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    idx_r <= idx_nxt; func_r <= func_nxt; dist_r <= dist_nxt; pw_r <= pw_nxt;
    k2_r <= k2_nxt; p2_r <= p2_nxt; k1_r <= k1_nxt; p1_r <= p1_nxt;
    prod_r <= prod_nxt; res_r <= res_nxt; stat_r <= stat_nxt;
    neg_r <= neg_nxt; hk_r <= hk_nxt; hv_r <= hv_nxt;
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_power = res_r;
  assign out_entry_count = 6'(cnt_r);
  assign out_status = stat_r;
endmodule

// ===== hdl/sorted_breakpoint_interpolation_table_unit.sv =====
// top level of the sorted breakpoint table with linear interpolation
// Usage:
//  input channel in_valid/in_stall carries func, distance and entry_power;
//  result channel out_valid/out_stall returns power, entry_count and status,
//  exactly one result per item, in order.
//  Items are processed one at a time. A linear scan reads one entry at a
//  time from the key and value memories (one read port each), through a
//  read state and a compare state per entry. An insert or delete then moves
//  each following entry through a read state and a write state. An
//  interpolating query adds a multiply state and a bit-serial division.
//  An unused function code skips the search and goes straight to the result,
//  and a new item is taken the cycle after its result is delivered.
//  Reset (synchronous, rst_n low) empties the table; memory contents are
//  left as they are and never read above the entry count.
//  While out_stall is high the result is held and no new item is accepted.
module sorted_breakpoint_interpolation_table_unit #(
  parameter int MAX_ENTRIES = sbit_pkg::MaxEntriesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_distance,
  input  logic signed [15:0] in_entry_power,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_power,
  output logic [5:0]         out_entry_count,
  output logic [1:0]         out_status
);
  localparam int AW = $clog2(MAX_ENTRIES);

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   key_wdata, val_wdata, key_rdata, val_rdata;
  sbit_pkg::div_req_t div_req;
  sbit_pkg::div_rsp_t div_rsp;

  sbit_ctrl #(.MaxEntries(MAX_ENTRIES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_distance, .in_entry_power,
    .out_valid, .out_stall, .out_power, .out_entry_count, .out_status,
    .mem_we, .mem_addr, .key_wdata, .val_wdata, .key_rdata, .val_rdata,
    .div_req, .div_rsp
  );

  sbit_ram #(.Width(16), .Depth(MAX_ENTRIES)) u_key_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(key_wdata), .rdata(key_rdata)
  );

  sbit_ram #(.Width(16), .Depth(MAX_ENTRIES)) u_val_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(val_wdata), .rdata(val_rdata)
  );

  sbit_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));
endmodule

// ===== hdl/sbit_checker.sv =====
// port-level checker for the breakpoint table, bound to the top level
`include "sorted_breakpoint_interpolation_table_unit_assert.svh"
module sbit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_entry_count,
  input logic [1:0]  out_status
);
  `SBIT_ASSERT_IMP(a_one_at_a_time, out_valid, in_stall, "item taken while result pending")
  `SBIT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_entry_count), "held")
  `SBIT_ASSERT_IMP(a_full_status, out_valid && out_status == sbit_pkg::ST_FULL, out_entry_count != 6'd0, "full on empty")
  `SBIT_ASSERT_NEXT(a_take, in_valid && !in_stall, in_stall, "no stall after taking an item")
endmodule

bind sorted_breakpoint_interpolation_table_unit sbit_checker u_sbit_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_entry_count, .out_status
);
